FILE: hdl/tnt_pkg.sv
`timescale 1ns / 1ps
// shared constants and width helpers for the triangle normal/tangent block
// no dependencies
package tnt_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int UNIT_FRAC_DEF   = 14;
  localparam int TEXV_WIDTH      = 16;
  localparam int OUT_WIDTH       = 16;
  // largest normalized magnitude lies in [2^30, 2^31)
  localparam int NORM_WIDTH      = 31;
  localparam int SUMSQ_WIDTH     = 64;
  localparam int ROOT_WIDTH      = 32;
  localparam int FIFO_DEPTH      = 4;

  // width of an exact raw normal or tangent component
  function automatic int raw_width(input int cw);
    int wn;
    int wt;
    wn = 2 * cw + 3;
    wt = cw + TEXV_WIDTH + 3;
    return (wn > wt) ? wn : wt;
  endfunction

endpackage

FILE: hdl/tnt_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for triangles in and unit vectors out
// depends on tnt_pkg
interface tnt_in_if #(
  parameter int CW = tnt_pkg::COORD_WIDTH_DEF
);
  logic valid;
  logic ready;
  logic signed [CW-1:0] p0_x, p0_y, p0_z;
  logic signed [CW-1:0] p1_x, p1_y, p1_z;
  logic signed [CW-1:0] p2_x, p2_y, p2_z;
  logic signed [tnt_pkg::TEXV_WIDTH-1:0] tex_v0, tex_v1, tex_v2;

  modport source(
    output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
    output tex_v0, tex_v1, tex_v2,
    input ready
  );
  modport sink(
    input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
    input tex_v0, tex_v1, tex_v2,
    output ready
  );
endinterface

interface tnt_out_if;
  logic valid;
  logic ready;
  logic signed [tnt_pkg::OUT_WIDTH-1:0] normal_x, normal_y, normal_z;
  logic signed [tnt_pkg::OUT_WIDTH-1:0] tangent_x, tangent_y, tangent_z;
  logic normal_degenerate;
  logic tangent_degenerate;

  modport source(
    output valid, normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
    output normal_degenerate, tangent_degenerate,
    input ready
  );
  modport sink(
    input valid, normal_x, normal_y, normal_z, tangent_x, tangent_y, tangent_z,
    input normal_degenerate, tangent_degenerate,
    output ready
  );
endinterface

FILE: hdl/tnt_front.sv
`timescale 1ns / 1ps
// front end: edge vectors, products and exact raw normal / tangent
// depends on tnt_pkg and tnt_in_if
module tnt_front #(
  parameter int CW = tnt_pkg::COORD_WIDTH_DEF,
  parameter int RW = tnt_pkg::raw_width(tnt_pkg::COORD_WIDTH_DEF)
) (
  input  logic clk,
  input  logic rst,
  tnt_in_if.sink tri_in,
  output logic push_valid,
  input  logic push_ready,
  output logic signed [RW-1:0] raw_n [3],
  output logic signed [RW-1:0] raw_t [3]
);
  import tnt_pkg::*;

  localparam int EW = CW + 1;
  localparam int DW = TEXV_WIDTH + 1;

  logic en;
  logic v1, v2, v3;
  logic signed [EW-1:0] e1 [3];
  logic signed [EW-1:0] e2 [3];
  logic signed [DW-1:0] dv1, dv2;
  logic signed [2*EW-1:0] pn [6];
  logic signed [EW+DW-1:0] pt [6];

  assign en = !v3 || push_ready;
  assign tri_in.ready = en;
  assign push_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= tri_in.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // edges from vertex 0 and v deltas
  always_ff @(posedge clk) begin
    if (en) begin
      e1[0] <= EW'(tri_in.p1_x) - EW'(tri_in.p0_x);
      e1[1] <= EW'(tri_in.p1_y) - EW'(tri_in.p0_y);
      e1[2] <= EW'(tri_in.p1_z) - EW'(tri_in.p0_z);
      e2[0] <= EW'(tri_in.p2_x) - EW'(tri_in.p0_x);
      e2[1] <= EW'(tri_in.p2_y) - EW'(tri_in.p0_y);
      e2[2] <= EW'(tri_in.p2_z) - EW'(tri_in.p0_z);
      dv1   <= DW'(tri_in.tex_v1) - DW'(tri_in.tex_v0);
      dv2   <= DW'(tri_in.tex_v2) - DW'(tri_in.tex_v0);
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      pn[0] <= e1[1] * e2[2];
      pn[1] <= e1[2] * e2[1];
      pn[2] <= e1[2] * e2[0];
      pn[3] <= e1[0] * e2[2];
      pn[4] <= e1[0] * e2[1];
      pn[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
        pt[2*i]   <= EW'(e1[i]) * dv2;
        pt[2*i+1] <= EW'(e2[i]) * dv1;
      end
    end
  end

  // differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        raw_n[i] <= RW'(pn[2*i]) - RW'(pn[2*i+1]);
        raw_t[i] <= RW'(pt[2*i]) - RW'(pt[2*i+1]);
      end
    end
  end

endmodule

FILE: hdl/tnt_fifo.sv
`timescale 1ns / 1ps
// small queue between front and back ends
// depends on tnt_pkg
module tnt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = tnt_pkg::FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  logic [W-1:0] push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output logic [W-1:0] pop_data
);
  import tnt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] count;
  logic [W-1:0] head;
  logic head_valid;
  logic do_push, do_pop;
  logic load, from_mem, bypass, do_write;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = head_valid;
  assign pop_data   = head;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = head_valid && pop_ready;
  // head register takes the oldest stored entry, or the incoming one when the store is empty
  assign load       = !head_valid || do_pop;
  assign from_mem   = load && (count != '0);
  assign bypass     = load && (count == '0) && do_push;
  assign do_write   = do_push && !bypass;

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wp] <= push_data;
    end
    if (from_mem) begin
      head <= mem[rp];
    end else if (bypass) begin
      head <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (do_write) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (from_mem) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_write && !from_mem) begin
        count <= count + 1'b1;
      end else if (from_mem && !do_write) begin
        count <= count - 1'b1;
      end
      if (load) begin
        head_valid <= from_mem || bypass;
      end
    end
  end

endmodule

FILE: hdl/tnt_unit.sv
`timescale 1ns / 1ps
// pipelined unit-vector scaler: normalize shift, sum of squares, sqrt, divide
// depends on tnt_pkg
module tnt_unit #(
  parameter int RW = tnt_pkg::raw_width(tnt_pkg::COORD_WIDTH_DEF),
  parameter int F  = tnt_pkg::UNIT_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [RW-1:0] raw [3],
  output logic out_valid,
  output logic signed [tnt_pkg::OUT_WIDTH-1:0] comp [3],
  output logic degen
);
  import tnt_pkg::*;

  localparam int LW   = $clog2(RW + 1);
  localparam int SQN  = ROOT_WIDTH;             // one root bit per stage
  localparam int NUMW = ROOT_WIDTH + F;         // dividend width
  localparam int QW   = F + 1;                  // quotient never exceeds 2^F
  localparam int LAT  = 5 + SQN + 1 + QW + 1;

  logic [LAT-1:0] vpipe;

  // magnitude stage
  logic [RW-1:0] mag1 [3];
  logic [2:0] neg1;
  // leading bit stage
  logic [RW-1:0] mag2 [3];
  logic [2:0] neg2;
  logic [LW-1:0] len2;
  logic zero2;
  logic [RW-1:0] mor;
  logic [LW-1:0] len_c;
  // shift stage
  logic [NORM_WIDTH-1:0] s3 [3];
  logic [2:0] neg3;
  logic zero3;
  logic [RW+NORM_WIDTH-1:0] wide [3];
  // square stage
  logic [2*NORM_WIDTH-1:0] sq4 [3];
  logic [NORM_WIDTH-1:0] s4 [3];
  logic [2:0] neg4;
  logic zero4;

  // sqrt pipe, index 0 holds the sum of squares
  logic [SUMSQ_WIDTH-1:0] sq_rem  [SQN+1];
  logic [ROOT_WIDTH-1:0]  sq_root [SQN+1];
  logic [NORM_WIDTH-1:0]  sq_s    [SQN+1][3];
  logic [2:0]             sq_neg  [SQN+1];
  logic                   sq_zero [SQN+1];

  // divide pipe, index 0 holds the rounded dividends
  logic [NUMW-1:0]       dv_rem  [QW+1][3];
  logic [QW-1:0]         dv_q    [QW+1][3];
  logic [ROOT_WIDTH-1:0] dv_r    [QW+1];
  logic [2:0]            dv_neg  [QW+1];
  logic                  dv_zero [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= raw[i][RW-1];
        mag1[i] <= raw[i][RW-1] ? RW'(-raw[i]) : RW'(raw[i]);
      end
    end
  end

  // bit length of the largest magnitude
  always_comb begin
    mor = mag1[0] | mag1[1] | mag1[2];
    len_c = '0;
    for (int k = 0; k < RW; k++) begin
      if (mor[k]) begin
        len_c = LW'(k + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2  <= mag1;
      neg2  <= neg1;
      len2  <= len_c;
      zero2 <= len_c == '0;
    end
  end

  // common shift so the largest lands in [2^30, 2^31)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {mag2[i], {NORM_WIDTH{1'b0}}} >> len2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3[i] <= wide[i][NORM_WIDTH-1:0];
      end
      neg3  <= neg2;
      zero3 <= zero2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= s3[i] * s3[i];
      end
      s4    <= s3;
      neg4  <= neg3;
      zero4 <= zero3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= SUMSQ_WIDTH'(sq4[0]) + SUMSQ_WIDTH'(sq4[1]) + SUMSQ_WIDTH'(sq4[2]);
      sq_root[0] <= '0;
      sq_s[0]    <= s4;
      sq_neg[0]  <= neg4;
      sq_zero[0] <= zero4;
    end
  end

  // restoring square root, most significant root bit first
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam int B = SQN - 1 - k;
    logic [SUMSQ_WIDTH+1:0] trial;
    assign trial = ((SUMSQ_WIDTH+2)'(sq_root[k]) << (B + 1))
                 | ((SUMSQ_WIDTH+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if ((SUMSQ_WIDTH+2)'(sq_rem[k]) >= trial) begin
          sq_rem[k+1]  <= sq_rem[k] - trial[SUMSQ_WIDTH-1:0];
          sq_root[k+1] <= sq_root[k] | (ROOT_WIDTH'(1) << B);
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
        sq_s[k+1]    <= sq_s[k];
        sq_neg[k+1]  <= sq_neg[k];
        sq_zero[k+1] <= sq_zero[k];
      end
    end
  end

  // rounded dividend: component * 2^F + root / 2
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NUMW'(sq_s[SQN][i]) << F) + NUMW'(sq_root[SQN] >> 1);
        dv_q[0][i]   <= '0;
      end
      dv_r[0]    <= sq_root[SQN];
      dv_neg[0]  <= sq_neg[SQN];
      dv_zero[0] <= sq_zero[SQN];
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    logic [NUMW-1:0] dsh;
    assign dsh = NUMW'(dv_r[j]) << K;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= dsh) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - dsh;
            dv_q[j+1][i]   <= dv_q[j][i] | (QW'(1) << K);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_r[j+1]    <= dv_r[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_zero[j+1] <= dv_zero[j];
      end
    end
  end

  // sign and zero-vector handling
  always_ff @(posedge clk) begin
    logic [31:0] qx;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qx = 32'(dv_q[QW][i]);
        if (dv_zero[QW]) begin
          comp[i] <= '0;
        end else if (dv_neg[QW][i]) begin
          comp[i] <= OUT_WIDTH'(-qx);
        end else begin
          comp[i] <= OUT_WIDTH'(qx);
        end
      end
      degen <= dv_zero[QW];
    end
  end

endmodule

FILE: hdl/tnt_back.sv
`timescale 1ns / 1ps
// back end: scales normal and tangent to unit length and drives the result channel
// depends on tnt_pkg, tnt_unit and tnt_out_if
module tnt_back #(
  parameter int RW = tnt_pkg::raw_width(tnt_pkg::COORD_WIDTH_DEF),
  parameter int F  = tnt_pkg::UNIT_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [RW-1:0] raw_n [3],
  input  logic signed [RW-1:0] raw_t [3],
  tnt_out_if.source res_out
);
  import tnt_pkg::*;

  logic en;
  logic vn, vt;
  logic signed [OUT_WIDTH-1:0] cn [3];
  logic signed [OUT_WIDTH-1:0] ct [3];
  logic dn, dt;

  // the last stage of both units is the output register
  assign en       = !(vn && vt) || res_out.ready;
  assign in_ready = en;

  tnt_unit #(.RW(RW), .F(F)) u_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .raw(raw_n),
    .out_valid(vn), .comp(cn), .degen(dn)
  );

  tnt_unit #(.RW(RW), .F(F)) u_tang (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .raw(raw_t),
    .out_valid(vt), .comp(ct), .degen(dt)
  );

  assign res_out.valid              = vn && vt;
  assign res_out.normal_x           = cn[0];
  assign res_out.normal_y           = cn[1];
  assign res_out.normal_z           = cn[2];
  assign res_out.tangent_x          = ct[0];
  assign res_out.tangent_y          = ct[1];
  assign res_out.tangent_z          = ct[2];
  assign res_out.normal_degenerate  = dn;
  assign res_out.tangent_degenerate = dt;

endmodule

FILE: hdl/triangle_normal_tangent.sv
`timescale 1ns / 1ps
// Triangle face normal and v-tangent engine. Takes one triangle transaction per
// cycle on tri_in while res_out keeps up, and returns one transaction on res_out
// holding the unit normal (e1 x e2) and unit tangent (e1*dv2 - e2*dv1) in signed
// fixed point with UNIT_FRACTION_BITS fraction bits, plus a degenerate flag for
// each vector that is exactly zero (its components then read zero). Sustained
// rate is one triangle per clock unless res_out stalls. A triangle passes the
// front-end registers, the queue's head register and the back-end pipeline,
// whose depth is set by the 32-stage square root and the one-bit-per-stage
// divider. The queue lets the front end keep taking triangles while a finished
// result waits for res_out.ready. No state survives between triangles and there
// are no configuration registers.
// depends on tnt_pkg, tnt_if, tnt_front, tnt_fifo, tnt_back
module triangle_normal_tangent #(
  parameter int COORD_WIDTH        = tnt_pkg::COORD_WIDTH_DEF,
  parameter int UNIT_FRACTION_BITS = tnt_pkg::UNIT_FRAC_DEF
) (
  input  logic clk,
  input  logic rst,
  tnt_in_if.sink tri_in,
  tnt_out_if.source res_out
);
  import tnt_pkg::*;

  // exact raw component width, for both normal and tangent
  localparam int RW = raw_width(COORD_WIDTH);
  localparam int QDW = 6 * RW;

  logic signed [RW-1:0] f_raw_n [3];
  logic signed [RW-1:0] f_raw_t [3];
  logic signed [RW-1:0] b_raw_n [3];
  logic signed [RW-1:0] b_raw_t [3];
  logic f_valid, f_ready;
  logic b_valid, b_ready;
  logic [QDW-1:0] q_in, q_out;

  // front end: edges, products, raw vectors
  tnt_front #(.CW(COORD_WIDTH), .RW(RW)) u_front (
    .clk(clk), .rst(rst), .tri_in(tri_in),
    .push_valid(f_valid), .push_ready(f_ready),
    .raw_n(f_raw_n), .raw_t(f_raw_t)
  );

  assign q_in = {f_raw_n[0], f_raw_n[1], f_raw_n[2],
                 f_raw_t[0], f_raw_t[1], f_raw_t[2]};

  // queue decouples the two ends
  tnt_fifo #(.W(QDW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(q_in),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(q_out)
  );

  assign b_raw_n[0] = q_out[6*RW-1:5*RW];
  assign b_raw_n[1] = q_out[5*RW-1:4*RW];
  assign b_raw_n[2] = q_out[4*RW-1:3*RW];
  assign b_raw_t[0] = q_out[3*RW-1:2*RW];
  assign b_raw_t[1] = q_out[2*RW-1:RW];
  assign b_raw_t[2] = q_out[RW-1:0];

  // back end: unit scaling and result register
  tnt_back #(.RW(RW), .F(UNIT_FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst),
    .in_valid(b_valid), .in_ready(b_ready),
    .raw_n(b_raw_n), .raw_t(b_raw_t),
    .res_out(res_out)
  );

endmodule

FILE: hdl/tnt_checker.sv
`timescale 1ns / 1ps
// port-level checks for the triangle normal/tangent block, bound to the top level
// depends on triangle_normal_tangent and tnt_pkg
module tnt_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic signed [tnt_pkg::OUT_WIDTH-1:0] nx, ny, nz,
  input logic signed [tnt_pkg::OUT_WIDTH-1:0] tx, ty, tz,
  input logic n_degen,
  input logic t_degen
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_norm_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && n_degen |-> nx == 0 && ny == 0 && nz == 0)
    else $error("degenerate normal with nonzero components");

  a_tang_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && t_degen |-> tx == 0 && ty == 0 && tz == 0)
    else $error("degenerate tangent with nonzero components");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result transaction right after reset");

endmodule

bind triangle_normal_tangent tnt_checker u_tnt_checker (
  .clk(clk), .rst(rst),
  .out_valid(res_out.valid), .out_ready(res_out.ready),
  .nx(res_out.normal_x), .ny(res_out.normal_y), .nz(res_out.normal_z),
  .tx(res_out.tangent_x), .ty(res_out.tangent_y), .tz(res_out.tangent_z),
  .n_degen(res_out.normal_degenerate), .t_degen(res_out.tangent_degenerate)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for triangle_normal_tangent: random and directed triangles,
// exact integer prediction of unit normal and tangent, random stalls on both sides
// depends on tnt_pkg, tnt_if and the triangle_normal_tangent rtl
module testbench;
  import tnt_pkg::*;

  typedef struct {
    logic signed [15:0] pos[9];
    logic signed [15:0] texv[3];
  } triangle_t;

  typedef struct {
    logic signed [15:0] nrm[3];
    logic signed [15:0] tan[3];
    bit nrm_degen;
    bit tan_degen;
  } unit_pair_t;

  // scoreboard: predicts unit normal/tangent for each accepted triangle
  class tri_scoreboard;
    unit_pair_t expected_q[$];
    int mismatches;
    int checked;

    function int pending();
      return expected_q.size();
    endfunction

    function logic signed [127:0] wide_mul(longint a, longint b);
      logic signed [127:0] x;
      logic signed [127:0] y;
      x = a;
      y = b;
      return x * y;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // scale to unit length: common shift puts largest magnitude in [2^30, 2^31)
    function void to_unit(input logic signed [127:0] v[3],
                          output logic signed [15:0] o[3], output bit degen);
      logic [127:0] mag[3];
      bit neg[3];
      logic [63:0] shifted[3];
      logic [63:0] sumsq;
      logic [63:0] root;
      logic [63:0] quo;
      int lmax;
      lmax = 0;
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        neg[i] = v[i][127];
        mag[i] = neg[i] ? -v[i] : v[i];
        for (int b = 127; b >= 0; b--)
          if (mag[i][b] && b + 1 > lmax) lmax = b + 1;
      end
      if (lmax == 0) begin
        for (int i = 0; i < 3; i++) o[i] = 0;
        degen = 1;
        return;
      end
      for (int i = 0; i < 3; i++) begin
        if (lmax <= 31) shifted[i] = 64'(mag[i] << (31 - lmax));
        else shifted[i] = 64'(mag[i] >> (lmax - 31));
        sumsq = sumsq + shifted[i] * shifted[i];
      end
      root = int_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
        quo = ((shifted[i] << UNIT_FRAC_DEF) + (root >> 1)) / root;
        o[i] = neg[i] ? 16'(-quo) : 16'(quo);
      end
      degen = 0;
    endfunction

    function void note_triangle(triangle_t t);
      longint e1[3];
      longint e2[3];
      longint dv1;
      longint dv2;
      logic signed [127:0] nraw[3];
      logic signed [127:0] traw[3];
      unit_pair_t r;
      for (int i = 0; i < 3; i++) begin
        e1[i] = longint'(t.pos[3 + i]) - longint'(t.pos[i]);
        e2[i] = longint'(t.pos[6 + i]) - longint'(t.pos[i]);
      end
      dv1 = longint'(t.texv[1]) - longint'(t.texv[0]);
      dv2 = longint'(t.texv[2]) - longint'(t.texv[0]);
      nraw[0] = wide_mul(e1[1], e2[2]) - wide_mul(e1[2], e2[1]);
      nraw[1] = wide_mul(e1[2], e2[0]) - wide_mul(e1[0], e2[2]);
      nraw[2] = wide_mul(e1[0], e2[1]) - wide_mul(e1[1], e2[0]);
      for (int i = 0; i < 3; i++)
        traw[i] = wide_mul(e1[i], dv2) - wide_mul(e2[i], dv1);
      to_unit(nraw, r.nrm, r.nrm_degen);
      to_unit(traw, r.tan, r.tan_degen);
      expected_q.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at result %0d: %s got %0d expected %0d",
               checked, what, got, want);
      mismatches++;
    endtask

    task check_result(unit_pair_t got);
      unit_pair_t want;
      if (expected_q.size() == 0) begin
        $display("unexpected result transaction with nothing outstanding");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.nrm[i] !== want.nrm[i]) report($sformatf("normal[%0d]", i), got.nrm[i], want.nrm[i]);
        if (got.tan[i] !== want.tan[i]) report($sformatf("tangent[%0d]", i), got.tan[i], want.tan[i]);
      end
      if (got.nrm_degen !== want.nrm_degen)
        report("normal_degenerate", got.nrm_degen, want.nrm_degen);
      if (got.tan_degen !== want.tan_degen)
        report("tangent_degenerate", got.tan_degen, want.tan_degen);
      checked++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  tnt_in_if tri_in();
  tnt_out_if res_out();

  triangle_normal_tangent u_top (
    .clk(clk),
    .rst(rst),
    .tri_in(tri_in.sink),
    .res_out(res_out.source)
  );

  always #10 clk = ~clk;

  tri_scoreboard sb = new();
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int sent = 0;

  // receiver: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (rst) begin
      res_out.ready = 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_out.ready = 0;
    end else if (hold_served < hold_requests) begin
      hold_served = hold_served + 1;
      hold_left = 300;
      res_out.ready = 0;
    end else begin
      res_out.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: both channels sampled on the rising edge
  always @(posedge clk) begin
    unit_pair_t got;
    triangle_t t;
    if (!rst && tri_in.valid && tri_in.ready) begin
      t.pos = '{tri_in.p0_x, tri_in.p0_y, tri_in.p0_z, tri_in.p1_x, tri_in.p1_y,
                tri_in.p1_z, tri_in.p2_x, tri_in.p2_y, tri_in.p2_z};
      t.texv = '{tri_in.tex_v0, tri_in.tex_v1, tri_in.tex_v2};
      sb.note_triangle(t);
    end
    if (!rst && res_out.valid && res_out.ready) begin
      got.nrm = '{res_out.normal_x, res_out.normal_y, res_out.normal_z};
      got.tan = '{res_out.tangent_x, res_out.tangent_y, res_out.tangent_z};
      got.nrm_degen = res_out.normal_degenerate;
      got.tan_degen = res_out.tangent_degenerate;
      sb.check_result(got);
    end
  end

  // present one triangle, with random idle cycles ahead of it
  task send_triangle(triangle_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      tri_in.valid = 0;
    end
    @(negedge clk);
    {tri_in.p0_x, tri_in.p0_y, tri_in.p0_z} = {t.pos[0], t.pos[1], t.pos[2]};
    {tri_in.p1_x, tri_in.p1_y, tri_in.p1_z} = {t.pos[3], t.pos[4], t.pos[5]};
    {tri_in.p2_x, tri_in.p2_y, tri_in.p2_z} = {t.pos[6], t.pos[7], t.pos[8]};
    {tri_in.tex_v0, tri_in.tex_v1, tri_in.tex_v2} = {t.texv[0], t.texv[1], t.texv[2]};
    tri_in.valid = 1;
    do @(posedge clk); while (!tri_in.ready);
    sent++;
  endtask

  function triangle_t make_triangle(int lo_v, int hi_v);
    triangle_t t;
    for (int i = 0; i < 9; i++) t.pos[i] = 16'($urandom_range(hi_v - lo_v) + lo_v);
    for (int i = 0; i < 3; i++) t.texv[i] = 16'($urandom_range(hi_v - lo_v) + lo_v);
    return t;
  endfunction

  // random triangle: mostly full range, some small and some degenerate shapes
  function triangle_t random_triangle();
    triangle_t t;
    int kind;
    int base;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) t.pos[i] = 16'($urandom);
    for (int i = 0; i < 3; i++) t.texv[i] = 16'($urandom);
    if (kind < 25) begin
      // small triangle around a random anchor, exercises left shifts
      base = $urandom_range(60000) - 30000;
      for (int i = 0; i < 9; i++) t.pos[i] = 16'(base + $urandom_range(16) - 8);
      for (int i = 0; i < 3; i++) t.texv[i] = 16'(base + $urandom_range(6) - 3);
    end else if (kind < 33) begin
      // collinear: p2 = p0 + k*(p1 - p0) with small k
      base = $urandom_range(4) - 2;
      for (int i = 0; i < 3; i++) begin
        t.pos[i] = 16'($urandom_range(2000) - 1000);
        t.pos[3 + i] = 16'(t.pos[i] + $urandom_range(200) - 100);
        t.pos[6 + i] = 16'(t.pos[i] + base * (t.pos[3 + i] - t.pos[i]));
      end
    end else if (kind < 40) begin
      // flat texture v: tangent collapses to zero
      t.texv[1] = t.texv[0];
      t.texv[2] = t.texv[0];
    end else if (kind < 45) begin
      // corners of the coordinate range
      for (int i = 0; i < 9; i++) t.pos[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      for (int i = 0; i < 3; i++) t.texv[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    return t;
  endfunction

  initial begin
    triangle_t t;
    triangle_t dir_q[$];
    tri_in.valid = 0;
    {tri_in.p0_x, tri_in.p0_y, tri_in.p0_z} = '0;
    {tri_in.p1_x, tri_in.p1_y, tri_in.p1_z} = '0;
    {tri_in.p2_x, tri_in.p2_y, tri_in.p2_z} = '0;
    {tri_in.tex_v0, tri_in.tex_v1, tri_in.tex_v2} = '0;
    tx_idle_pct = 9;
    rx_idle_pct = 58;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: all zero (both degenerate), unit axes, extremes, flat texture
    t = make_triangle(0, 0);
    dir_q.push_back(t);
    t.pos = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    t.texv = '{0, 0, 1};
    dir_q.push_back(t);
    t.pos = '{0, 0, 0, 0, 1, 0, 0, 0, 1};
    t.texv = '{0, 1, 0};
    dir_q.push_back(t);
    t.pos = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    t.texv = '{-32768, 32767, -32768};
    dir_q.push_back(t);
    t.pos = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
    t.texv = '{32767, -32768, -32768};
    dir_q.push_back(t);
    t.pos = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
    t.texv = '{-32768, 32767, 32767};
    dir_q.push_back(t);
    t.pos = '{5, 5, 5, 5, 5, 5, 5, 5, 5};
    t.texv = '{-32768, 32767, 0};
    dir_q.push_back(t);
    t.pos = '{0, 0, 0, 3, 6, 9, 1, 2, 3};
    t.texv = '{100, 200, 300};
    dir_q.push_back(t);
    t.pos = '{1, 2, 3, 4, -5, 6, -7, 8, 9};
    t.texv = '{7, 7, 7};
    dir_q.push_back(t);
    t.pos = '{-1, -1, -1, 0, -1, -1, -1, 0, -1};
    t.texv = '{-1, -1, -1};
    dir_q.push_back(t);
    t.pos = '{32767, 0, 0, -32768, 0, 0, 0, 32767, -32768};
    t.texv = '{16384, -16384, 16384};
    dir_q.push_back(t);
    t.pos = '{0, 0, 0, 1000, 1, 0, 0, 1, 1000};
    t.texv = '{0, 32767, -32768};
    dir_q.push_back(t);
    foreach (dir_q[i]) send_triangle(dir_q[i]);

    // random traffic in three stall regimes
    for (int n = 0; n < 1450; n++) begin
      if (n == 480) begin
        tx_idle_pct = 58;
        rx_idle_pct = 9;
      end
      if (n == 960) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // long receiver hold-off while the sender keeps pushing
      if (n == 200 || n == 1000) hold_requests = hold_requests + 1;
      // sender drains completely once
      if (n == 700) begin
        @(negedge clk);
        tri_in.valid = 0;
        while (sb.pending() != 0) @(posedge clk);
      end
      send_triangle(random_triangle());
    end
    @(negedge clk);
    tri_in.valid = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d triangles, checked %0d normal/tangent results", sent, sb.checked);
    $display("covered range corners, zero and collinear shapes, flat texture and stalls");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", sb.pending());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
